### hdl/double_hash_table_macros.svh
// assertion macros for the double hash table
// used by dht_mod_unit and double_hash_table; no other dependencies
`ifndef DOUBLE_HASH_TABLE_MACROS_SVH
`define DOUBLE_HASH_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("double_hash_table: check failed");
// next-cycle implication
`define DHT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("double_hash_table: check failed");
`else
`define DHT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DHT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/dht_pkg.sv
// shared types and constants for the double hash table
// no dependencies
package dht_pkg;

    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int STEP_W   = 4;
    localparam int CFG_IDX_W = 1;

    localparam int TABLE_SIZE_RST = 11;
    localparam int STEP_BASE_RST  = 5;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_BASE  = 1'd1;

    typedef struct packed {
        logic ever_used;
        logic occupied;
    } slot_flags_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_stat_t;

endpackage

### hdl/dht_if.sv
// request and response channel interfaces for the double hash table
// depends on dht_pkg
interface dht_req_if #(
    parameter int KEY_BITS = 31
);
    logic                      valid;
    logic                      ready;
    logic [dht_pkg::REQ_W-1:0] req_type;
    logic [KEY_BITS-1:0]       key;

    modport source (output valid, output req_type, output key, input ready);
    modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface dht_rsp_if #(
    parameter int IDX_W   = 4,
    parameter int ENTRY_W = 5
);
    logic                         valid;
    logic                         ready;
    logic [dht_pkg::STATUS_W-1:0] status;
    logic [IDX_W-1:0]             slot_index;
    logic [ENTRY_W-1:0]           entry_total;

    modport source (output valid, output status, output slot_index, output entry_total,
                    input ready);
    modport sink   (input valid, input status, input slot_index, input entry_total,
                    output ready);
endinterface

### hdl/dht_mod_unit.sv
// shared remainder unit: restoring division, one dividend bit per cycle
// depends on dht_pkg and double_hash_table_macros.svh
`include "double_hash_table_macros.svh"

module dht_mod_unit #(
    parameter int DIVIDEND_W = 31,
    parameter int DIVISOR_W  = 5,
    parameter int CNT_W      = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [DIVIDEND_W-1:0]  dividend,
    input  logic [DIVISOR_W-1:0]   divisor,
    input  logic [CNT_W-1:0]       nbits,
    output logic [DIVISOR_W-1:0]   rem,
    output dht_pkg::mod_stat_t     stat
);

    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;
    logic [DIVIDEND_W-1:0] shift_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W:0]    partial;
    logic [DIVISOR_W:0]    diff;
    logic [DIVISOR_W-1:0]  rem_next;

    always_comb
    begin
        partial  = {rem_reg, shift_reg[DIVIDEND_W-1]};
        diff     = partial - {1'b0, divisor_reg};
        rem_next = (partial >= {1'b0, divisor_reg}) ? diff[DIVISOR_W-1:0]
                                                     : partial[DIVISOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= nbits;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg   <= dividend;
            divisor_reg <= divisor;
            rem_reg     <= '0;
        end
        else if (cnt_reg != '0)
        begin
            shift_reg <= {shift_reg[DIVIDEND_W-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign rem       = rem_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

    `DHT_ASSERT_NXT(a_start_makes_busy, clk, rst_n, start && nbits != '0, cnt_reg != '0)

endmodule

### hdl/dht_slot_mem.sv
// slot store: key, occupied and used-ever bits per slot, registered read
// clears all flags in a sweep after reset; depends on dht_pkg
module dht_slot_mem #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 31,
    parameter int IDX_W    = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IDX_W-1:0]     rd_addr,
    output dht_pkg::slot_flags_t rd_flags,
    output logic [KEY_BITS-1:0]  rd_key,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  dht_pkg::slot_flags_t wr_flags,
    input  logic [KEY_BITS-1:0]  wr_key,
    output logic                 clearing
);

    localparam int ROW_W = KEY_BITS + 2;

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] clr_addr_reg;
    logic             clearing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            if (clr_addr_reg == IDX_W'(DEPTH - 1))
                clearing_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            mem[clr_addr_reg] <= '0;
        else if (wr_en)
            mem[wr_addr] <= {wr_flags, wr_key};
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_flags = rd_data_reg[ROW_W-1:KEY_BITS];
    assign rd_key   = rd_data_reg[KEY_BITS-1:0];
    assign clearing = clearing_reg;

endmodule

### hdl/double_hash_table.sv
// double hash table top level: config registers, request sequencer, result register
// depends on dht_pkg, dht_if, dht_mod_unit, dht_slot_mem, double_hash_table_macros.svh
//
//  channel | dir | transaction payload
//  --------+-----+----------------------------------------------
//  req     | in  | req_type, key
//  rsp     | out | status, slot_index, entry_total
//  cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
// after reset the slot flags are cleared in a sweep over all TABLE_DEPTH slots; req is ready
// once the sequencer has left S_CLEAR after the sweep. a request runs three remainder passes
// (key mod k, key mod size, step mod size, one bit a cycle) on the shared remainder unit, then
// probes the slot store's read port, one probe per cycle: 1 to size probes for lookup; an insert
// that misses restarts from home and probes up to size more slots for a free one.
// one request at a time; the next is taken while a result waits in the rsp register.
`include "double_hash_table_macros.svh"

module double_hash_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_BITS    = 31
) (
    input  logic                            clk,
    input  logic                            rst_n,
    dht_req_if.sink                         req,
    dht_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [dht_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [((($clog2(TABLE_DEPTH + 1)) > dht_pkg::STEP_W) ?
                   $clog2(TABLE_DEPTH + 1) : dht_pkg::STEP_W) - 1:0] cfg_data
);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int SIZE_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = SIZE_W;
    localparam int STEP_W  = dht_pkg::STEP_W;
    localparam int DIV_W   = (SIZE_W > STEP_W) ? SIZE_W : STEP_W;
    localparam int CNT_W   = $clog2(KEY_BITS + 1);
    localparam int SUM_W   = IDX_W + 1;
    localparam int SIZE_RST = (dht_pkg::TABLE_SIZE_RST > TABLE_DEPTH) ?
                              TABLE_DEPTH : dht_pkg::TABLE_SIZE_RST;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MODK  = 3'd2;
    localparam logic [2:0] S_MODN  = 3'd3;
    localparam logic [2:0] S_MODS  = 3'd4;
    localparam logic [2:0] S_ISSUE = 3'd5;
    localparam logic [2:0] S_CHK   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]                   state_reg, state_next;
    logic [SIZE_W-1:0]            size_reg;
    logic [STEP_W-1:0]            kbase_reg;
    logic [SIZE_W-1:0]            eff_n;
    logic [STEP_W-1:0]            eff_k;

    logic [dht_pkg::REQ_W-1:0]    req_type_reg;
    logic [KEY_BITS-1:0]          key_reg;
    logic [SIZE_W-1:0]            n_reg;
    logic [STEP_W-1:0]            k_reg;
    logic [STEP_W-1:0]            step_reg;
    logic [IDX_W-1:0]             home_reg;
    logic [IDX_W-1:0]             stride_reg;
    logic [IDX_W-1:0]             pos_reg;
    logic [IDX_W-1:0]             probe_reg;
    logic                         free_phase_reg;
    logic [ENTRY_W-1:0]           count_reg;
    logic [dht_pkg::STATUS_W-1:0] res_status_reg;
    logic [IDX_W-1:0]             res_slot_reg;

    logic                         rsp_valid_reg;
    logic [dht_pkg::STATUS_W-1:0] rsp_status_reg;
    logic [IDX_W-1:0]             rsp_slot_reg;
    logic [ENTRY_W-1:0]           rsp_total_reg;

    logic                         accept;
    logic                         mod_start;
    logic [KEY_BITS-1:0]          mod_dividend;
    logic [DIV_W-1:0]             mod_divisor;
    logic [CNT_W-1:0]             mod_nbits;
    logic [DIV_W-1:0]             mod_rem;
    dht_pkg::mod_stat_t           mod_stat;

    logic [IDX_W-1:0]             rd_addr;
    dht_pkg::slot_flags_t         rd_flags;
    logic [KEY_BITS-1:0]          rd_key;
    logic                         mem_wr_en;
    dht_pkg::slot_flags_t         wr_flags;
    logic                         mem_clearing;

    logic [SUM_W-1:0]             pos_sum;
    logic [IDX_W-1:0]             pos_adv;
    logic                         last_probe;
    logic                         chk_hit;
    logic                         chk_miss;
    logic                         chk_free;
    logic                         chk_full;
    logic                         out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= SIZE_W'(SIZE_RST);
            kbase_reg <= STEP_W'(dht_pkg::STEP_BASE_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dht_pkg::REG_TABLE_SIZE: size_reg  <= cfg_data[SIZE_W-1:0];
                dht_pkg::REG_STEP_BASE:  kbase_reg <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (size_reg < SIZE_W'(2))
            eff_n = SIZE_W'(2);
        else if (size_reg > SIZE_W'(TABLE_DEPTH))
            eff_n = SIZE_W'(TABLE_DEPTH);
        else
            eff_n = size_reg;
        eff_k = (kbase_reg == '0) ? STEP_W'(1) : kbase_reg;
    end

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !rsp_valid_reg || rsp.ready;

    // remainder unit operand select
    always_comb
    begin
        mod_start    = 1'b0;
        mod_dividend = key_reg;
        mod_divisor  = DIV_W'(n_reg);
        mod_nbits    = CNT_W'(KEY_BITS);
        case (state_reg)
            S_IDLE:
            begin
                mod_start    = accept;
                mod_dividend = req.key;
                mod_divisor  = DIV_W'(eff_k);
            end
            S_MODK:
                mod_start = mod_stat.done;
            S_MODN:
            begin
                mod_start    = mod_stat.done;
                // step sits in the top bits so only its STEP_W bits are divided
                mod_dividend = {step_reg, {(KEY_BITS - STEP_W){1'b0}}};
                mod_nbits    = CNT_W'(STEP_W);
            end
            default: ;
        endcase
    end

    dht_mod_unit #(
        .DIVIDEND_W (KEY_BITS),
        .DIVISOR_W  (DIV_W),
        .CNT_W      (CNT_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dividend),
        .divisor  (mod_divisor),
        .nbits    (mod_nbits),
        .rem      (mod_rem),
        .stat     (mod_stat)
    );

    // next probe position, one compare and subtract since stride < size
    always_comb
    begin
        pos_sum = SUM_W'(pos_reg) + SUM_W'(stride_reg);
        if (pos_sum >= SUM_W'(n_reg))
            pos_sum = pos_sum - SUM_W'(n_reg);
        pos_adv = pos_sum[IDX_W-1:0];
    end

    assign last_probe = (probe_reg == IDX_W'(n_reg - SIZE_W'(1)));

    always_comb
    begin
        chk_hit  = 1'b0;
        chk_miss = 1'b0;
        chk_free = 1'b0;
        chk_full = 1'b0;
        if (state_reg == S_CHK)
        begin
            if (!free_phase_reg)
            begin
                if (rd_flags.ever_used && rd_flags.occupied && rd_key == key_reg)
                    chk_hit = 1'b1;
                else if (!rd_flags.ever_used || last_probe)
                    chk_miss = 1'b1;
            end
            else
            begin
                if (!rd_flags.occupied)
                    chk_free = 1'b1;
                else if (last_probe)
                    chk_full = 1'b1;
            end
        end
    end

    always_comb
    begin
        mem_wr_en          = 1'b0;
        wr_flags.ever_used = 1'b1;
        wr_flags.occupied  = 1'b1;
        if (chk_free)
            mem_wr_en = 1'b1;
        else if (chk_hit && req_type_reg == dht_pkg::REQ_REMOVE)
        begin
            // tombstone: keep used-ever, drop occupied
            mem_wr_en         = 1'b1;
            wr_flags.occupied = 1'b0;
        end
    end

    assign rd_addr = (state_reg == S_CHK) ? pos_adv : pos_reg;

    dht_slot_mem #(
        .DEPTH    (TABLE_DEPTH),
        .KEY_BITS (KEY_BITS),
        .IDX_W    (IDX_W)
    ) u_slots (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (rd_addr),
        .rd_flags (rd_flags),
        .rd_key   (rd_key),
        .wr_en    (mem_wr_en),
        .wr_addr  (pos_reg),
        .wr_flags (wr_flags),
        .wr_key   (key_reg),
        .clearing (mem_clearing)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (!mem_clearing) state_next = S_IDLE;
            S_IDLE:  if (accept) state_next = S_MODK;
            S_MODK:  if (mod_stat.done) state_next = S_MODN;
            S_MODN:  if (mod_stat.done) state_next = S_MODS;
            S_MODS:  if (mod_stat.done) state_next = S_ISSUE;
            S_ISSUE: state_next = S_CHK;
            S_CHK:
            begin
                if (chk_miss && req_type_reg == dht_pkg::REQ_INSERT)
                    state_next = S_ISSUE;
                else if (chk_hit || chk_miss || chk_free || chk_full)
                    state_next = S_DONE;
            end
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (chk_free)
                count_reg <= count_reg + ENTRY_W'(1);
            else if (chk_hit && req_type_reg == dht_pkg::REQ_REMOVE)
                count_reg <= count_reg - ENTRY_W'(1);
        end
    end

    // request datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_type_reg <= req.req_type;
                    key_reg      <= req.key;
                    n_reg        <= eff_n;
                    k_reg        <= eff_k;
                end
            end
            S_MODK:
                if (mod_stat.done)
                    step_reg <= k_reg - mod_rem[STEP_W-1:0];
            S_MODN:
                if (mod_stat.done)
                    home_reg <= mod_rem[IDX_W-1:0];
            S_MODS:
            begin
                if (mod_stat.done)
                begin
                    stride_reg     <= mod_rem[IDX_W-1:0];
                    pos_reg        <= home_reg;
                    probe_reg      <= '0;
                    free_phase_reg <= 1'b0;
                end
            end
            S_CHK:
            begin
                if (chk_hit)
                begin
                    res_slot_reg <= pos_reg;
                    case (req_type_reg)
                        dht_pkg::REQ_INSERT: res_status_reg <= dht_pkg::ST_PRESENT;
                        dht_pkg::REQ_REMOVE: res_status_reg <= dht_pkg::ST_DONE;
                        dht_pkg::REQ_FIND:   res_status_reg <= dht_pkg::ST_DONE;
                        default:
                        begin
                            res_status_reg <= dht_pkg::ST_NOT_FOUND;
                            res_slot_reg   <= '0;
                        end
                    endcase
                end
                else if (chk_miss)
                begin
                    res_status_reg <= dht_pkg::ST_NOT_FOUND;
                    res_slot_reg   <= '0;
                    // insert goes on to search for a free slot from home
                    pos_reg        <= home_reg;
                    probe_reg      <= '0;
                    free_phase_reg <= 1'b1;
                end
                else if (chk_free)
                begin
                    res_status_reg <= dht_pkg::ST_DONE;
                    res_slot_reg   <= pos_reg;
                end
                else if (chk_full)
                begin
                    res_status_reg <= dht_pkg::ST_FULL;
                    res_slot_reg   <= '0;
                end
                else
                begin
                    pos_reg   <= pos_adv;
                    probe_reg <= probe_reg + IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (state_reg == S_DONE && out_free)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_slot_reg   <= res_slot_reg;
            rsp_total_reg  <= count_reg;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.slot_index  = rsp_slot_reg;
    assign rsp.entry_total = rsp_total_reg;

    `DHT_ASSERT_NOW(a_write_only_on_check, clk, rst_n, mem_wr_en, state_reg == S_CHK)
    `DHT_ASSERT_NOW(a_no_accept_while_clearing, clk, rst_n, mem_clearing, !req.ready)
    `DHT_ASSERT_NXT(a_accept_starts_mod, clk, rst_n, req.valid && req.ready, mod_stat.busy)

endmodule
